@@ rtl/core/raised_cosine_fade_gain_macros.svh @@
// Assertion helpers for the fader RTL.
`ifndef RAISED_COSINE_FADE_GAIN_MACROS_SVH
`define RAISED_COSINE_FADE_GAIN_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define RCFG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fader check failed");
// Check that nxt holds in the cycle after cond.
`define RCFG_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("fader check failed");
`else
`define RCFG_ASSERT(lbl, clk, rst_n, prop)
`define RCFG_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)
`endif
`endif

@@ rtl/core/rcfg_pkg.sv @@
package rcfg_pkg;

    localparam int CHANNELS        = 4;
    localparam int SAMPLE_BITS     = 24;
    localparam int COS_TABLE_DEPTH = 1024;

    localparam int IDX_BITS   = $clog2(COS_TABLE_DEPTH);
    localparam int LEN_BITS   = 24;
    localparam int GAIN_BITS  = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int W_BITS     = GAIN_FRAC + 1;
    localparam int G2_BITS    = 2 * GAIN_BITS;
    localparam int WPROD_BITS = GAIN_BITS + W_BITS + 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = GAIN_BITS;

    localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(1 << GAIN_FRAC);

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    localparam int              TAYLOR_TERMS = 7;
    localparam int              RECIP_SHIFT  = 42;
    localparam longint unsigned RECIP_ONE    = 64'd1 << RECIP_SHIFT;
    // rounded-up reciprocals of (2k-1)*2k, exact for numerators below 2^34
    localparam longint unsigned TAYLOR_RECIP [TAYLOR_TERMS] = '{
        (RECIP_ONE + 64'd1)   / 64'd2,
        (RECIP_ONE + 64'd11)  / 64'd12,
        (RECIP_ONE + 64'd29)  / 64'd30,
        (RECIP_ONE + 64'd55)  / 64'd56,
        (RECIP_ONE + 64'd89)  / 64'd90,
        (RECIP_ONE + 64'd131) / 64'd132,
        (RECIP_ONE + 64'd181) / 64'd182
    };

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OUT_GAIN,
        REG_MUTED
    } cfg_reg_t;

    typedef enum logic {
        REQ_FRAME,
        REQ_FADE
    } req_t;

    typedef struct packed {
        logic                start;
        logic [LEN_BITS-1:0] num;
        logic [LEN_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [IDX_BITS-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic               mul_en;
        logic [G2_BITS-1:0] gain;
    } lane_ctrl_t;

    typedef logic [W_BITS-1:0] wtab_t [COS_TABLE_DEPTH];

    // cos^2(pi*i/(2*depth)) in Q1.14 from a truncated Taylor series in Q30
    function automatic logic [W_BITS-1:0] raised_cos_entry(int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned c;
        longint unsigned w;
        longint          sum;
        logic [127:0]    qprod;
        x   = (PI_Q30 * longint'(i)) / (2 * COS_TABLE_DEPTH);
        x2  = (x * x) >> 30;
        t   = ONE_Q30;
        sum = longint'(ONE_Q30);
        for (int k = 1; k <= 7; k++) begin
            qprod = 128'((t * x2) >> 30) * 128'(TAYLOR_RECIP[k - 1]);
            t     = qprod[RECIP_SHIFT +: 64];
            if (k % 2 == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        c = longint'(sum);
        w = (c * c + (64'd1 << 45)) >> 46;
        return w[W_BITS-1:0];
    endfunction

    function automatic wtab_t build_wtab();
        wtab_t tab;
        for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
            tab[i] = raised_cos_entry(i);
        end
        return tab;
    endfunction

    localparam wtab_t WTAB = build_wtab();

endpackage

@@ rtl/core/rcfg_div.sv @@
module rcfg_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  rcfg_pkg::div_req_t req,
    output rcfg_pkg::div_rsp_t rsp
);
    import rcfg_pkg::*;

    localparam int CNT_BITS = $clog2(IDX_BITS);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [LEN_BITS-1:0] rem_reg;
    logic [LEN_BITS-1:0] rem_next;
    logic [LEN_BITS-1:0] den_reg;
    logic [IDX_BITS-1:0] quot_reg;
    logic [LEN_BITS:0]   shifted;
    logic                qbit;

    // one quotient bit per cycle; the numerator is always below the divisor
    always_comb begin
        shifted  = {rem_reg, 1'b0};
        qbit     = shifted >= {1'b0, den_reg};
        rem_next = qbit ? LEN_BITS'(shifted - {1'b0, den_reg}) : shifted[LEN_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= req.num;
                den_reg  <= req.den;
                quot_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quot_reg <= {quot_reg[IDX_BITS-2:0], qbit};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(IDX_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ rtl/core/rcfg_lane.sv @@
module rcfg_lane (
    input  logic                                  aclk,
    input  logic signed [rcfg_pkg::SAMPLE_BITS-1:0] sample,
    input  rcfg_pkg::lane_ctrl_t                  ctrl,
    output logic signed [rcfg_pkg::SAMPLE_BITS-1:0] result
);
    import rcfg_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + G2_BITS + 1;
    localparam int SHIFT     = 2 * GAIN_FRAC;
    localparam logic signed [PROD_BITS-1:0] ROUND = PROD_BITS'(64'sd1 <<< (SHIFT - 1));
    localparam logic signed [PROD_BITS-1:0] SMAX  =
        PROD_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_BITS-1:0] SMIN  = -SMAX - PROD_BITS'(1);

    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] prod_next;
    logic signed [PROD_BITS-1:0] scaled;

    assign prod_next = PROD_BITS'(sample) * PROD_BITS'($signed({1'b0, ctrl.gain}));

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // round half up, floor shift, then clamp to the sample range
    always_comb begin
        scaled = (prod_reg + ROUND) >>> SHIFT;
        if (scaled > SMAX) begin
            result = SMAX[SAMPLE_BITS-1:0];
        end else if (scaled < SMIN) begin
            result = SMIN[SAMPLE_BITS-1:0];
        end else begin
            result = scaled[SAMPLE_BITS-1:0];
        end
    end

endmodule

@@ rtl/core/raised_cosine_fade_gain.sv @@
// Four-channel raised-cosine gain fader.
// Input channel (s_valid/s_ready): a sample frame (s_req_type 0) carries one
// sample per channel; a fade command (s_req_type 1) carries fade_target and
// fade_length and yields no result. Result channel (m_valid/m_ready): one item
// per frame with the scaled channels and the fading flag.
// Configuration (cfg_we/cfg_index/cfg_wdata): index 0 out_gain, index 1 muted;
// write only while the block is idle.
// Frame path: S_G2, S_LMUL, S_OUT while no fade runs; S_DIV, S_WMUL,
// S_GAIN first while a fade runs; S_OUT alone when muted. The next item is
// taken once the block is back in S_IDLE after the result register loads;
// a command leaves it in S_IDLE. A running fade adds the bit-serial index
// divider (one quotient bit per cycle), the table read and the gain
// multiply; channel scaling runs in parallel lanes, one multiplier each.
// A stalled receiver holds the result register; the block finishes the
// next frame and waits with it until the register frees.
// Reset (synchronous, aresetn low): unity gains, no fade, not muted, output
// register empty.
`include "raised_cosine_fade_gain_macros.svh"

module raised_cosine_fade_gain (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [rcfg_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [rcfg_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_req_type,
    input  logic signed [rcfg_pkg::SAMPLE_BITS-1:0] s_sample_0,
    input  logic signed [rcfg_pkg::SAMPLE_BITS-1:0] s_sample_1,
    input  logic signed [rcfg_pkg::SAMPLE_BITS-1:0] s_sample_2,
    input  logic signed [rcfg_pkg::SAMPLE_BITS-1:0] s_sample_3,
    input  logic [rcfg_pkg::GAIN_BITS-1:0]          s_fade_target,
    input  logic [rcfg_pkg::LEN_BITS-1:0]           s_fade_length,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [rcfg_pkg::SAMPLE_BITS-1:0] m_out_0,
    output logic signed [rcfg_pkg::SAMPLE_BITS-1:0] m_out_1,
    output logic signed [rcfg_pkg::SAMPLE_BITS-1:0] m_out_2,
    output logic signed [rcfg_pkg::SAMPLE_BITS-1:0] m_out_3,
    output logic                                    m_fading
);
    import rcfg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_WMUL,
        S_GAIN,
        S_G2,
        S_LMUL,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [GAIN_BITS-1:0] out_gain_reg, out_gain_next;
    logic                 muted_reg, muted_next;
    logic [LEN_BITS-1:0]  remaining_reg, remaining_next;
    logic [LEN_BITS-1:0]  total_reg, total_next;
    logic [GAIN_BITS-1:0] start_reg, start_next;
    logic [GAIN_BITS-1:0] end_reg, end_next;
    logic [GAIN_BITS-1:0] present_reg, present_next;
    logic                 m_valid_reg, m_valid_next;

    logic signed [SAMPLE_BITS-1:0] s_samples   [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] samples_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] lane_res    [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] out_reg     [CHANNELS];
    logic                          fading_reg;
    logic                          mute_frame_reg;
    logic [W_BITS-1:0]             w_reg;
    logic signed [WPROD_BITS-1:0]  wprod_reg;
    logic signed [WPROD_BITS-1:0]  wprod_next;
    logic signed [WPROD_BITS-1:0]  wrnd;
    logic [G2_BITS-1:0]            g2_reg;

    logic                accept;
    logic                out_free;
    logic [LEN_BITS-1:0] len_eff;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    lane_ctrl_t          lane_ctrl;

    assign s_samples[0] = s_sample_0;
    assign s_samples[1] = s_sample_1;
    assign s_samples[2] = s_sample_2;
    assign s_samples[3] = s_sample_3;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign len_eff  = (s_fade_length == '0) ? LEN_BITS'(1) : s_fade_length;

    assign wprod_next = WPROD_BITS'($signed({1'b0, end_reg}) - $signed({1'b0, start_reg}))
                      * WPROD_BITS'($signed({1'b0, w_reg}));
    assign wrnd = (wprod_reg + WPROD_BITS'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;

    always_comb begin
        state_next     = state_reg;
        out_gain_next  = out_gain_reg;
        muted_next     = muted_reg;
        remaining_next = remaining_reg;
        total_next     = total_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        present_next   = present_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        div_req.start  = 1'b0;
        div_req.num    = remaining_reg - 1'b1;
        div_req.den    = total_reg;

        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_OUT_GAIN: out_gain_next = cfg_wdata;
                REG_MUTED:    muted_next    = cfg_wdata[0];
                default:      ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_req_type == REQ_FADE) begin
                        // restart from wherever the gain stands now
                        start_next     = present_reg;
                        end_next       = s_fade_target;
                        total_next     = len_eff;
                        remaining_next = len_eff;
                    end else if (muted_reg) begin
                        state_next = S_OUT;
                    end else if (remaining_reg != '0) begin
                        remaining_next = remaining_reg - 1'b1;
                        div_req.start  = 1'b1;
                        state_next     = S_DIV;
                    end else begin
                        state_next = S_G2;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_WMUL;
                end
            end
            S_WMUL: state_next = S_GAIN;
            S_GAIN: begin
                present_next = start_reg + wrnd[GAIN_BITS-1:0];
                state_next   = S_G2;
            end
            S_G2:   state_next = S_LMUL;
            S_LMUL: state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_gain_reg  <= UNITY_GAIN;
            muted_reg     <= 1'b0;
            remaining_reg <= '0;
            total_reg     <= LEN_BITS'(1);
            start_reg     <= UNITY_GAIN;
            end_reg       <= UNITY_GAIN;
            present_reg   <= UNITY_GAIN;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_gain_reg  <= out_gain_next;
            muted_reg     <= muted_next;
            remaining_reg <= remaining_next;
            total_reg     <= total_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            present_reg   <= present_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            samples_reg    <= s_samples;
            mute_frame_reg <= muted_reg;
        end
        if (state_reg == S_DIV && div_rsp.done) begin
            w_reg <= WTAB[div_rsp.quot];
        end
        if (state_reg == S_WMUL) begin
            wprod_reg <= wprod_next;
        end
        if (state_reg == S_G2) begin
            g2_reg <= present_reg * out_gain_reg;
        end
        // merge the lanes into the result register
        if (state_reg == S_OUT && out_free) begin
            for (int c = 0; c < CHANNELS; c++) begin
                out_reg[c] <= mute_frame_reg ? '0 : lane_res[c];
            end
            fading_reg <= (remaining_reg != '0);
        end
    end

    rcfg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign lane_ctrl.mul_en = (state_reg == S_LMUL);
    assign lane_ctrl.gain   = g2_reg;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        rcfg_lane u_lane (
            .aclk   (aclk),
            .sample (samples_reg[c]),
            .ctrl   (lane_ctrl),
            .result (lane_res[c])
        );
    end

    assign m_valid  = m_valid_reg;
    assign m_out_0  = out_reg[0];
    assign m_out_1  = out_reg[1];
    assign m_out_2  = out_reg[2];
    assign m_out_3  = out_reg[3];
    assign m_fading = fading_reg;

    `RCFG_ASSERT(a_rem_le_total, aclk, aresetn, remaining_reg <= total_reg && total_reg != '0)
    `RCFG_ASSERT_NEXT(a_fade_load, aclk, aresetn, accept && s_req_type == REQ_FADE, remaining_reg == total_reg && state_reg == S_IDLE)
    `RCFG_ASSERT(a_div_done_state, aclk, aresetn, div_rsp.done |-> state_reg == S_DIV)
    `RCFG_ASSERT_NEXT(a_out_load, aclk, aresetn, state_reg == S_OUT && out_free, m_valid_reg && s_ready)

endmodule

@@ tb/sv/tb_raised_cosine_fade_gain.sv @@
`timescale 1ns / 1ps

module tb_raised_cosine_fade_gain;
    import rcfg_pkg::*;

    localparam int RUN_LIMIT     = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 40;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTED   = 60;
    localparam int PHASES        = 6;

    localparam longint unsigned TAYLOR_PI = 64'd3373259426;
    localparam longint unsigned Q30_ONE   = 64'd1073741824;
    localparam logic [GAIN_BITS-1:0] UNITY = 16'd16384;
    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam logic [SAMPLE_BITS-1:0] SMAX = 24'h7FFFFF;
    localparam logic [SAMPLE_BITS-1:0] SMIN = 24'h800000;

    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] chan_vec_t;

    typedef struct packed {
        req_t                 req;
        chan_vec_t            smp;
        logic [GAIN_BITS-1:0] target;
        logic [LEN_BITS-1:0]  length;
    } fade_item_t;

    typedef struct packed {
        chan_vec_t out;
        logic      fading;
    } frame_res_t;

    typedef enum {ROW_ITEM, ROW_CHECKED, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        fade_item_t               item;
        frame_res_t               want;
        cfg_reg_t                 sel;
        logic [CFG_DATA_BITS-1:0] val;
    } step_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_req_type;
    logic [SAMPLE_BITS-1:0]   s_sample_0, s_sample_1, s_sample_2, s_sample_3;
    logic [GAIN_BITS-1:0]     s_fade_target;
    logic [LEN_BITS-1:0]      s_fade_length;
    logic                     m_valid;
    logic                     m_ready;
    logic [SAMPLE_BITS-1:0]   m_out_0, m_out_1, m_out_2, m_out_3;
    logic                     m_fading;

    // fader state as the block should hold it
    logic [14:0]          fade_wt [COS_TABLE_DEPTH];
    logic [LEN_BITS-1:0]  fade_left;
    logic [LEN_BITS-1:0]  fade_len;
    logic [GAIN_BITS-1:0] gain_from;
    logic [GAIN_BITS-1:0] gain_to;
    logic [GAIN_BITS-1:0] gain_now;
    logic [GAIN_BITS-1:0] out_gain_cfg;
    logic                 mute_cfg;

    frame_res_t frame_expect [$];
    step_row_t  steps [$];
    int         mismatch_cnt = 0;
    int         results_seen = 0;
    int         cycle_count = 0;
    bit         hold_req = 1'b0;
    bit         no_idle = 1'b0;

    raised_cosine_fade_gain u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_sample_0   (s_sample_0),
        .s_sample_1   (s_sample_1),
        .s_sample_2   (s_sample_2),
        .s_sample_3   (s_sample_3),
        .s_fade_target(s_fade_target),
        .s_fade_length(s_fade_length),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_0      (m_out_0),
        .m_out_1      (m_out_1),
        .m_out_2      (m_out_2),
        .m_out_3      (m_out_3),
        .m_fading     (m_fading)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // cos^2 weight in Q1.14 from a Q30 Taylor series, truncated at each step
    function automatic logic [14:0] cos_sq_weight(int unsigned i);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint unsigned c;
        longint unsigned w;
        longint          acc;
        ang  = (TAYLOR_PI * i) / (2 * COS_TABLE_DEPTH);
        ang2 = (ang * ang) >> 30;
        term = Q30_ONE;
        acc  = Q30_ONE;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * ang2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(Q30_ONE)) begin
            acc = Q30_ONE;
        end
        c = acc;
        w = (c * c + (64'd1 << 45)) >> 46;
        return w[14:0];
    endfunction

    // apply one item to the fader state; return 1 when it yields a result
    function automatic bit advance_fader(input fade_item_t it, output frame_res_t res);
        longint unsigned left_u;
        longint unsigned len_u;
        longint unsigned idx;
        longint unsigned wt;
        longint unsigned mix;
        longint          samp;
        longint          g_fade;
        longint          g_out;
        longint          prod;
        res = '0;
        if (it.req == REQ_FADE) begin
            gain_from = gain_now;
            gain_to   = it.target;
            fade_len  = (it.length == '0) ? LEN_BITS'(1) : it.length;
            fade_left = fade_len;
            return 1'b0;
        end
        if (mute_cfg) begin
            res.fading = (fade_left != '0);
            return 1'b1;
        end
        if (fade_left != '0) begin
            fade_left = fade_left - 1'b1;
            left_u = fade_left;
            len_u  = fade_len;
            idx = (left_u * COS_TABLE_DEPTH) / len_u;
            if (idx >= COS_TABLE_DEPTH) begin
                idx = COS_TABLE_DEPTH - 1;
            end
            wt  = fade_wt[idx];
            mix = (longint'(gain_from) * (UNITY - wt) + longint'(gain_to) * wt + 8192) >> 14;
            gain_now = mix[GAIN_BITS-1:0];
        end
        g_fade = gain_now;
        g_out  = out_gain_cfg;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            samp = $signed(it.smp[ch]);
            prod = (samp * g_fade * g_out + 134217728) >>> 28;
            if (prod > SAT_HI) begin
                prod = SAT_HI;
            end
            if (prod < SAT_LO) begin
                prod = SAT_LO;
            end
            res.out[ch] = prod[SAMPLE_BITS-1:0];
        end
        res.fading = (fade_left != '0);
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        if (mismatch_cnt < MAX_PRINTED) begin
            $display("%0t result %0d: %s got %0d expected %0d", $realtime, results_seen, what,
                     got, want);
        end
        mismatch_cnt++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return SMAX;
            1: return SMIN;
            2: return SAMPLE_BITS'($urandom_range(0, 511)) - SAMPLE_BITS'(256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic fade_item_t draw_item(input req_t req, input logic [LEN_BITS-1:0] len);
        fade_item_t it;
        it.req = req;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            it.smp[ch] = draw_sample();
        end
        case ($urandom_range(0, 5))
            0: it.target = '0;
            1: it.target = '1;
            2: it.target = UNITY;
            default: it.target = GAIN_BITS'($urandom);
        endcase
        it.length = len;
        return it;
    endfunction

    task automatic add_item(input req_t req, input chan_vec_t smp, input logic [15:0] tgt,
                            input logic [23:0] len);
        step_row_t row;
        row.kind = ROW_ITEM;
        row.item = '{req: req, smp: smp, target: tgt, length: len};
        row.want = '0;
        row.sel  = REG_OUT_GAIN;
        row.val  = '0;
        steps.insert(steps.size(), row);
    endtask

    task automatic add_checked(input chan_vec_t smp, input chan_vec_t out, input logic fading);
        step_row_t row;
        row.kind = ROW_CHECKED;
        row.item = '{req: REQ_FRAME, smp: smp, target: 16'h3C3C, length: 24'hC3C3C3};
        row.want = '{out: out, fading: fading};
        row.sel  = REG_OUT_GAIN;
        row.val  = '0;
        steps.insert(steps.size(), row);
    endtask

    task automatic add_write(input cfg_reg_t sel, input logic [CFG_DATA_BITS-1:0] val);
        step_row_t row;
        row.kind = ROW_WRITE;
        row.item = '0;
        row.want = '0;
        row.sel  = sel;
        row.val  = val;
        steps.insert(steps.size(), row);
    endtask

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic offer_item(input fade_item_t it, input bit typed, input frame_res_t want);
        frame_res_t res;
        int         gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type    <= it.req;
        s_sample_0    <= it.smp[0];
        s_sample_1    <= it.smp[1];
        s_sample_2    <= it.smp[2];
        s_sample_3    <= it.smp[3];
        s_fade_target <= it.target;
        s_fade_length <= it.length;
        s_valid       <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (advance_fader(it, res)) begin
            frame_expect.insert(frame_expect.size(), typed ? want : res);
        end
        @(negedge aclk);
    endtask

    // hold the input until all results are out and the block has gone quiet
    task automatic quiesce();
        s_valid <= 1'b0;
        while (frame_expect.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        case (sel)
            REG_OUT_GAIN: out_gain_cfg = val[GAIN_BITS-1:0];
            REG_MUTED:    mute_cfg = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        int                       ph;
        int                       sent;
        int                       quota;
        int                       run;
        int                       span;
        int                       pick;
        int                       waited;
        bit                       hold_done;
        bit                       drain_done;
        logic [GAIN_BITS-1:0]     gain;
        logic [LEN_BITS-1:0]      len;

        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_OUT_GAIN;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_req_type    <= REQ_FRAME;
        s_sample_0    <= '0;
        s_sample_1    <= '0;
        s_sample_2    <= '0;
        s_sample_3    <= '0;
        s_fade_target <= '0;
        s_fade_length <= '0;

        for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
            fade_wt[i] = cos_sq_weight(i);
        end
        fade_left    = '0;
        fade_len     = LEN_BITS'(1);
        gain_from    = UNITY;
        gain_to      = UNITY;
        gain_now     = UNITY;
        out_gain_cfg = UNITY;
        mute_cfg     = 1'b0;
        hold_done    = 1'b0;
        drain_done   = 1'b0;

        // unity gains pass samples through, jumps land on the target at once
        add_checked({24'hFFFFFF, 24'h000000, SMIN, SMAX}, {24'hFFFFFF, 24'h000000, SMIN, SMAX},
                    1'b0);
        add_item(REQ_FADE, {4{24'h5A5A5A}}, 16'h0000, 24'd0);
        add_checked({SMAX, SMIN, 24'h123456, 24'hFFFFFF}, '0, 1'b0);
        add_item(REQ_FADE, {4{24'hA5A5A5}}, 16'hFFFF, 24'd0);
        add_checked({24'h000000, 24'h000000, SMIN, SMAX}, {24'h000000, 24'h000000, SMIN, SMAX},
                    1'b0);
        // short fade run to its end, then hold
        add_item(REQ_FADE, '0, 16'h4000, 24'd3);
        repeat (4) add_item(REQ_FRAME, {24'h400000, 24'hC00000, 24'h000001, SMAX}, 16'hFFFF,
                            24'hFFFFFF);
        add_item(REQ_FADE, {4{24'hFFFFFF}}, 16'h1F40, 24'd5);
        repeat (2) add_item(REQ_FRAME, {SMIN, 24'h2AAAAA, 24'hD55555, 24'h000100}, 16'h0000,
                            24'd0);
        // restart while a fade is running
        add_item(REQ_FADE, '0, 16'h7FFF, 24'd4);
        add_item(REQ_FRAME, {SMAX, SMAX, SMIN, SMIN}, 16'h8000, 24'h800000);
        // muted: zero out, fade frozen, commands still apply
        add_write(REG_MUTED, 16'h0001);
        add_item(REQ_FRAME, {SMAX, SMIN, 24'h7F0000, 24'h00FFFF}, 16'h0000, 24'd0);
        add_item(REQ_FADE, '0, 16'h2000, 24'hFFFFFF);
        add_item(REQ_FRAME, {SMAX, SMIN, 24'h7F0000, 24'h00FFFF}, 16'h0000, 24'd0);
        add_write(REG_MUTED, 16'h0000);
        repeat (2) add_item(REQ_FRAME, {SMAX, SMIN, 24'h7F0000, 24'h00FFFF}, 16'hFFFF,
                            24'h000001);
        add_write(REG_OUT_GAIN, 16'h0000);
        add_checked({SMAX, SMIN, 24'h7F0000, 24'h00FFFF}, '0, 1'b1);
        add_write(REG_OUT_GAIN, 16'hFFFF);
        add_item(REQ_FRAME, {SMAX, SMIN, 24'h000001, 24'hFFFFFF}, 16'hFFFF, 24'hFFFFFF);
        add_write(REG_OUT_GAIN, UNITY);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (steps[n]) begin
            case (steps[n].kind)
                ROW_WRITE: begin
                    quiesce();
                    write_reg(steps[n].sel, steps[n].val);
                end
                ROW_CHECKED: offer_item(steps[n].item, 1'b1, steps[n].want);
                default:     offer_item(steps[n].item, 1'b0, '0);
            endcase
        end

        for (ph = 0; ph < PHASES; ph++) begin
            quiesce();
            case (ph)
                0: gain = UNITY;
                1: gain = GAIN_BITS'($urandom_range(8192, 32768));
                2: gain = 16'hFFFF;
                4: gain = 16'h0000;
                default: gain = GAIN_BITS'($urandom);
            endcase
            write_reg(REG_OUT_GAIN, gain);
            write_reg(REG_MUTED, {15'($urandom), ph == 3});
            no_idle = (ph == 5);
            quota = (ph == 4) ? 40 : 120;
            sent = 0;
            while (sent < quota) begin
                if (ph == 1 && sent >= 10 && !hold_done) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                if (ph == 2 && sent >= 60 && !drain_done) begin
                    quiesce();
                    drain_done = 1'b1;
                end
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    // fade followed by span to span + 3 frames; a zero span may leave it unfinished
                    span = $urandom_range(0, 24);
                    offer_item(draw_item(REQ_FADE, LEN_BITS'(span)), 1'b0, '0);
                    run = span + $urandom_range(0, 3);
                    sent++;
                end else if (pick < 8) begin
                    // long fade, cut short by whatever comes next
                    case ($urandom_range(0, 2))
                        0: len = LEN_BITS'($urandom_range(25, 3000));
                        1: len = '1;
                        default: len = LEN_BITS'($urandom);
                    endcase
                    offer_item(draw_item(REQ_FADE, len), 1'b0, '0);
                    run = $urandom_range(1, 10);
                    sent++;
                end else begin
                    run = $urandom_range(1, 6);
                end
                repeat (run) offer_item(draw_item(REQ_FRAME, LEN_BITS'($urandom)), 1'b0, '0);
                sent += run;
            end
        end

        s_valid <= 1'b0;
        for (waited = 0; waited < DRAIN_LIMIT && frame_expect.size() != 0; waited++) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (frame_expect.size() != 0) begin
            note_mismatch("results never arrived", 0, frame_expect.size());
        end
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // result side: short and long stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) begin
                    stall_left = gap_len();
                end
            end
        end
    end

    always @(posedge aclk) begin
        frame_res_t want;
        chan_vec_t  seen;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_out_3, m_out_2, m_out_1, m_out_0};
            if (frame_expect.size() == 0) begin
                note_mismatch("result with nothing pending", 0, 0);
            end else begin
                want = frame_expect.pop_front();
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    if (seen[ch] !== want.out[ch]) begin
                        note_mismatch($sformatf("out_%0d", ch), $signed(seen[ch]),
                                      $signed(want.out[ch]));
                    end
                end
                if (m_fading !== want.fading) begin
                    note_mismatch("fading", m_fading, want.fading);
                end
            end
            results_seen++;
        end
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
